// File: rtl/core/debounced_button_hex_counter_display_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the debounced button hex counter display core
// Included by the checker file. Every macro samples on clk and is held off
// while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DEBOUNCED_BUTTON_HEX_COUNTER_DISPLAY_CORE_DEFINES_SVH
`define DEBOUNCED_BUTTON_HEX_COUNTER_DISPLAY_CORE_DEFINES_SVH

// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define DBHCD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> (cons)) else $error("dbhcd same-cycle check failed");

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define DBHCD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |=> (cons)) else $error("dbhcd next-cycle check failed");

`endif

// File: rtl/core/dbhcd_pkg.sv
// ----------------------------------------------------------------------------
// dbhcd_pkg
// Shared constants, types and the hex to seven-segment decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dbhcd_pkg;

	localparam int unsigned HISTORY_DEPTH = 12;
	localparam int unsigned BUTTON_WIDTH  = 8;
	localparam int unsigned COUNT_WIDTH   = 16;

	typedef logic [BUTTON_WIDTH-1:0] button_t;
	typedef logic [COUNT_WIDTH-1:0]  count_t;
	typedef logic [7:0]              seg_code_t;

	localparam seg_code_t SEG_BLANK = 8'hFF;

	// active-low segment code, bit 7 is the decimal point (off)
	function automatic seg_code_t hex_to_seg(input logic [3:0] nib);
		seg_code_t code;
		case (nib)
			4'h0: code = 8'hC0;
			4'h1: code = 8'hF9;
			4'h2: code = 8'hA4;
			4'h3: code = 8'hB0;
			4'h4: code = 8'h99;
			4'h5: code = 8'h92;
			4'h6: code = 8'h82;
			4'h7: code = 8'hF8;
			4'h8: code = 8'h80;
			4'h9: code = 8'h98;
			4'hA: code = 8'h88;
			4'hB: code = 8'h83;
			4'hC: code = 8'hC6;
			4'hD: code = 8'hA1;
			4'hE: code = 8'h86;
			4'hF: code = 8'h8E;
			default: code = SEG_BLANK;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/dbhcd_in_if.sv
// ----------------------------------------------------------------------------
// dbhcd_in_if
// Input channel: one raw active-low button sample per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dbhcd_in_if import dbhcd_pkg::*;;
	logic    valid;
	logic    ready;
	button_t raw_buttons;

	modport source (output valid, output raw_buttons, input ready);
	modport sink   (input valid, input raw_buttons, output ready);
endinterface

`default_nettype wire

// File: rtl/core/dbhcd_out_if.sv
// ----------------------------------------------------------------------------
// dbhcd_out_if
// Result channel: debounced mask, press flag, counter and display codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dbhcd_out_if import dbhcd_pkg::*;;
	logic      valid;
	logic      ready;
	button_t   debounced_mask;
	logic      press_event;
	count_t    count_value;
	seg_code_t seg_digit0;
	seg_code_t seg_digit1;
	seg_code_t seg_colon;
	seg_code_t seg_digit2;
	seg_code_t seg_digit3;

	modport source (
		output valid, output debounced_mask, output press_event, output count_value,
		output seg_digit0, output seg_digit1, output seg_colon, output seg_digit2,
		output seg_digit3, input ready
	);
	modport sink (
		input valid, input debounced_mask, input press_event, input count_value,
		input seg_digit0, input seg_digit1, input seg_colon, input seg_digit2,
		input seg_digit3, output ready
	);
endinterface

`default_nettype wire

// File: rtl/core/debounced_button_hex_counter_display_core.sv
// ----------------------------------------------------------------------------
// debounced_button_hex_counter_display_core
// Debounces eight active-low buttons, counts presses and drives hex codes.
// ----------------------------------------------------------------------------
// Usage:
//   sample : one raw active-low button byte per beat (0 = pressed).
//   result : one beat per sample, carrying the debounced mask (AND of the
//            last HISTORY_DEPTH samples), the press flag, the 16-bit running
//            count and four active-low hex digit codes plus a blank colon.
//   Path:    an accepted sample goes to the input register, then is loaded
//            into the result register and shows on result from then on.
//   Throughput: one beat per cycle while result.ready is high; the state
//            update sits between the input and the result register.
//   Reset: arst_n clears the history, the held flag, the count and both
//            valid flags; the first results see an all-released history.
//   Stall: while result.ready is low the result register holds its beat;
//            one more sample may wait in the input register, after which
//            sample.ready drops until the receiver takes the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module debounced_button_hex_counter_display_core import dbhcd_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	dbhcd_in_if.sink     sample,
	dbhcd_out_if.source  result
);

	// input stage
	logic    valid_s1;
	button_t raw_s1;

	// block state
	button_t hist_q [HISTORY_DEPTH];
	logic    held_q;
	count_t  total_q;

	// result register
	logic      out_valid_q;
	button_t   mask_q;
	logic      event_q;
	count_t    count_q;
	seg_code_t digit_q [4];

	logic      advance;
	button_t   pressed;
	button_t   mask_new;
	logic      hit;
	count_t    total_new;
	logic      blank3;
	logic      blank2;
	logic      blank1;
	seg_code_t code_new [4];

	// move the input stage on when the result register is empty or being taken
	assign advance      = valid_s1 && (!out_valid_q || result.ready);
	assign sample.ready = !valid_s1 || advance;

	// invert to 1 = pressed; the new sample plus the youngest DEPTH-1 entries
	// make up the window after this beat
	always_comb begin
		pressed  = ~raw_s1;
		mask_new = pressed;
		for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
			mask_new = mask_new & hist_q[i];
		end
	end

	// count only the first non-zero mask after a zero mask
	assign hit       = (mask_new != '0) && !held_q;
	assign total_new = hit ? count_t'(total_q + count_t'(mask_new)) : total_q;

	// leading zero blanking runs from digit 3 down; digit 0 is always shown
	assign blank3 = (total_new[15:12] == 4'h0);
	assign blank2 = blank3 && (total_new[11:8] == 4'h0);
	assign blank1 = blank2 && (total_new[7:4] == 4'h0);

	always_comb begin
		code_new[0] = hex_to_seg(total_new[3:0]);
		code_new[1] = blank1 ? SEG_BLANK : hex_to_seg(total_new[7:4]);
		code_new[2] = blank2 ? SEG_BLANK : hex_to_seg(total_new[11:8]);
		code_new[3] = blank3 ? SEG_BLANK : hex_to_seg(total_new[15:12]);
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			raw_s1 <= sample.raw_buttons;
		end
	end

	// history shift line, held flag and counter advance once per beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
			held_q  <= 1'b0;
			total_q <= '0;
		end else if (advance) begin
			hist_q[0] <= pressed;
			for (int i = 1; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= hist_q[i-1];
			end
			held_q  <= (mask_new != '0);
			total_q <= total_new;
		end
	end

	// result register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mask_q  <= mask_new;
			event_q <= hit;
			count_q <= total_new;
			for (int d = 0; d < 4; d++) begin
				digit_q[d] <= code_new[d];
			end
		end
	end

	assign result.valid          = out_valid_q;
	assign result.debounced_mask = mask_q;
	assign result.press_event    = event_q;
	assign result.count_value    = count_q;
	assign result.seg_digit0     = digit_q[0];
	assign result.seg_digit1     = digit_q[1];
	assign result.seg_colon      = SEG_BLANK;
	assign result.seg_digit2     = digit_q[2];
	assign result.seg_digit3     = digit_q[3];

endmodule

`default_nettype wire

// File: rtl/core/dbhcd_checker.sv
// ----------------------------------------------------------------------------
// dbhcd_checker
// Port-level checks on the result channel, bound to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "debounced_button_hex_counter_display_core_defines.svh"

module dbhcd_checker import dbhcd_pkg::*; (
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire button_t   debounced_mask,
	input wire logic      press_event,
	input wire count_t    count_value,
	input wire seg_code_t seg_digit0,
	input wire seg_code_t seg_colon,
	input wire seg_code_t seg_digit2,
	input wire seg_code_t seg_digit3
);

	// hold a stalled beat
	`DBHCD_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(count_value) && $stable(debounced_mask))
	// a counted press always comes from a non-zero mask
	`DBHCD_ASSERT_NOW(a_event_mask, out_valid && press_event, debounced_mask != '0)
	// colon always blank, lowest digit always lit
	`DBHCD_ASSERT_NOW(a_colon_digit0, out_valid, seg_colon == SEG_BLANK && seg_digit0 != SEG_BLANK)
	// a lit top digit forbids blanking digit 2
	`DBHCD_ASSERT_NOW(a_blank_order, out_valid && seg_digit3 != SEG_BLANK, seg_digit2 != SEG_BLANK)

endmodule

bind debounced_button_hex_counter_display_core dbhcd_checker u_dbhcd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.debounced_mask (result.debounced_mask),
	.press_event    (result.press_event),
	.count_value    (result.count_value),
	.seg_digit0     (result.seg_digit0),
	.seg_colon      (result.seg_colon),
	.seg_digit2     (result.seg_digit2),
	.seg_digit3     (result.seg_digit3)
);

`default_nettype wire

// File: dv/dbhcd_count_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbhcd_count_monitor
// Watches the sample and result channels and keeps its own model of the
// debounce window, the press counter and the hex display. Each result beat
// is compared field by field with the oldest predicted beat.
// ----------------------------------------------------------------------------

module dbhcd_count_monitor import dbhcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	dbhcd_in_if         in_ch,
	dbhcd_out_if        out_ch,
	output int unsigned mismatch_count,
	output int unsigned beats_waiting
);

	typedef struct packed {
		button_t   mask;
		logic      press;
		count_t    count;
		seg_code_t digit0;
		seg_code_t digit1;
		seg_code_t colon;
		seg_code_t digit2;
		seg_code_t digit3;
	} display_beat_t;

	// active-low segment font, digits 0 to F
	localparam seg_code_t HEX_FONT [16] = '{
		8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8,
		8'h80, 8'h98, 8'h88, 8'h83, 8'hC6, 8'hA1, 8'h86, 8'h8E
	};

	button_t       sample_ring [HISTORY_DEPTH];
	int unsigned   ring_slot;
	logic          press_held;
	count_t        press_total;
	display_beat_t expected_beats [$];

	task automatic note_failure(input string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	task automatic check_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got)
			note_failure($sformatf("%s expected 0x%0h actual 0x%0h", field, want, got));
	endtask

	// Advance the window by one sample and queue the beat it produces.
	task automatic take_sample(input button_t raw);
		button_t       window;
		logic [3:0]    nib [4];
		seg_code_t     code [4];
		logic          leading;
		display_beat_t beat;
		int            d;
		sample_ring[ring_slot] = ~raw;
		ring_slot = (ring_slot == HISTORY_DEPTH - 1) ? 0 : ring_slot + 1;
		window = '1;
		for (d = 0; d < HISTORY_DEPTH; d++)
			window &= sample_ring[d];
		beat.press = 1'b0;
		if (window != '0) begin
			// count only the first tick of a hold, whatever the mask does later
			if (!press_held) begin
				press_held  = 1'b1;
				press_total = press_total + count_t'(window);
				beat.press  = 1'b1;
			end
		end else begin
			press_held = 1'b0;
		end
		for (d = 0; d < 4; d++) begin
			nib[d]  = press_total[d*4 +: 4];
			code[d] = HEX_FONT[nib[d]];
		end
		// blank leading zeros from the top down; digit 0 always shows
		leading = 1'b1;
		for (d = 3; d >= 1; d--) begin
			if (leading && nib[d] == 4'h0)
				code[d] = SEG_BLANK;
			else
				leading = 1'b0;
		end
		beat.mask   = window;
		beat.count  = press_total;
		beat.digit0 = code[0];
		beat.digit1 = code[1];
		beat.colon  = SEG_BLANK;
		beat.digit2 = code[2];
		beat.digit3 = code[3];
		expected_beats.push_back(beat);
	endtask

	always @(posedge clk or negedge arst_n) begin
		display_beat_t want;
		if (!arst_n) begin
			for (int k = 0; k < HISTORY_DEPTH; k++)
				sample_ring[k] = '0;
			ring_slot      = 0;
			press_held     = 1'b0;
			press_total    = '0;
			mismatch_count = 0;
			expected_beats.delete();
			beats_waiting <= 0;
		end else begin
			// compare before queueing: a sample never leaves in its own cycle
			if (out_ch.valid && out_ch.ready) begin
				if (expected_beats.size() == 0) begin
					note_failure("result beat with nothing expected");
				end else begin
					want = expected_beats.pop_front();
					check_field("debounced_mask", want.mask, out_ch.debounced_mask);
					check_field("press_event", want.press, out_ch.press_event);
					check_field("count_value", want.count, out_ch.count_value);
					check_field("seg_digit0", want.digit0, out_ch.seg_digit0);
					check_field("seg_digit1", want.digit1, out_ch.seg_digit1);
					check_field("seg_colon", want.colon, out_ch.seg_colon);
					check_field("seg_digit2", want.digit2, out_ch.seg_digit2);
					check_field("seg_digit3", want.digit3, out_ch.seg_digit3);
				end
			end
			if (in_ch.valid && in_ch.ready)
				take_sample(in_ch.raw_buttons);
			beats_waiting <= expected_beats.size();
		end
	end

endmodule

// File: dv/debounced_button_hex_counter_display_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_button_hex_counter_display_core_test
// Drives raw button samples into the debounce counter core and stalls its
// result channel at random. A short directed opening covers full presses,
// holds that change mask and releases; random press sequences follow, then
// a run of heavy presses that push the count up fast. The monitor beside
// the core predicts every result beat and counts mismatches.
// ----------------------------------------------------------------------------

module debounced_button_hex_counter_display_core_test;
	import dbhcd_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        steady;
	int unsigned beats_sent;
	int unsigned mismatch_count;
	int unsigned beats_waiting;

	dbhcd_in_if  sample_ch ();
	dbhcd_out_if result_ch ();

	debounced_button_hex_counter_display_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch)
	);

	dbhcd_count_monitor u_monitor (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_ch          (sample_ch),
		.out_ch         (result_ch),
		.mismatch_count (mismatch_count),
		.beats_waiting  (beats_waiting)
	);

	always #10 clk = ~clk;

	// Receiver: drops ready at random with a chance of 7 in 100, never while steady is set.
	always @(posedge clk) begin
		if (arst_n)
			result_ch.ready <= steady || ($urandom_range(0, 99) >= 7);
	end

	// Offer one sample beat and hold it until the core takes it. Idle cycles
	// go in front of the beat, so valid is only ever assigned once per edge.
	task automatic send_beat(input button_t raw);
		while (!steady && $urandom_range(0, 99) < 7) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid       <= 1'b1;
		sample_ch.raw_buttons <= raw;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		beats_sent++;
	endtask

	// Lead beat, then a run of samples that all press held_bits; a run of
	// twelve or more after a full release fills the window and counts.
	// Sparse extra presses ride on top as bounce.
	task automatic send_press_run(input button_t lead_raw, input button_t held_bits,
			input int unsigned run_len);
		button_t     extra;
		int unsigned i;
		send_beat(lead_raw);
		for (i = 0; i < run_len; i++) begin
			extra = button_t'($urandom & $urandom & $urandom);
			send_beat(~(held_bits | extra));
		end
	endtask

	// Drop valid and hold off until every predicted beat has come back.
	// Step one edge first so the count includes the last accepted sample.
	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (beats_waiting != 0)
			@(posedge clk);
	endtask

	initial begin
		int unsigned pick;
		int unsigned i;
		bit          paused;
		arst_n                = 1'b0;
		steady                = 1'b0;
		beats_sent            = 0;
		paused                = 1'b0;
		sample_ch.valid       = 1'b0;
		sample_ch.raw_buttons = '0;
		result_ch.ready       = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening. Reset leaves the window all released, so eleven
		// full presses show no mask and the twelfth counts 0xff.
		repeat (12) send_beat(8'h00);
		// hold changes to a single button: mask shrinks, nothing is added
		send_beat(8'hFE);
		// full release: mask drops to zero and the hold is cleared
		send_beat(8'hFF);
		// alternate buttons; the release leaves the window on the twelfth beat
		repeat (12) send_beat(8'hAA);
		drain_results();

		// Random press sequences, mostly well formed, with broken runs and
		// plain noise mixed in.
		while (beats_sent < 300) begin
			pick = $urandom_range(0, 99);
			if (pick < 75)
				send_press_run($urandom_range(0, 1) ? 8'hFF : button_t'($urandom),
					button_t'($urandom_range(1, 255)), 12 + $urandom_range(0, 6));
			else if (pick < 90)
				send_press_run(button_t'($urandom), button_t'($urandom_range(1, 255)),
					$urandom_range(1, 11));
			else
				repeat ($urandom_range(1, 5)) send_beat(button_t'($urandom));
			if (!paused && beats_sent > 160) begin
				drain_results();
				paused = 1'b1;
			end
		end

		// Heavy presses: every count adds at least 0xe0. Run the first half
		// with no idling on either side.
		steady <= 1'b1;
		for (i = 0; i < 16; i++) begin
			if (i == 8)
				steady <= 1'b0;
			send_press_run(8'hFF, 8'hE0 | button_t'($urandom_range(0, 31)), 12);
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0 && beats_waiting == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Watchdog: the whole run needs well under a tenth of this.
	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule
